// ===== rtl/core/binary_image_centroid_core_macros.svh =====
// Assertion macros used by the controller of the binary image centroid core.
`ifndef BINARY_IMAGE_CENTROID_CORE_MACROS_SVH
`define BINARY_IMAGE_CENTROID_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge outside reset.
`define BCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcc assertion failed");
// Next-cycle implication, checked on the rising edge outside reset.
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcc assertion failed");
`else
`define BCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/bcc_pkg.sv =====
// Package with widths, register indexes, control structs and helpers of the centroid core.
package bcc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 8;
  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int QUO_W = 12;
  localparam int CNT_W = 25;
  localparam int SUM_W = 36;
  localparam int IDX_W = 2;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic div_start;
    logic load_out;
  } bcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_last;
    logic div_busy;
  } bcc_status_t;

  // A zero dimension acts as one, and a dimension above the maximum saturates.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bcc_pixel_if.sv =====
// Pixel request channel: valid, ready and one grayscale pixel.
interface bcc_pixel_if
  import bcc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== rtl/core/bcc_result_if.sv =====
// Result request channel: valid, ready and the centroid of one frame.
interface bcc_result_if
  import bcc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [QUO_W-1:0] center_x;
  logic [QUO_W-1:0] center_y;
  logic [CNT_W-1:0] hit_count;
  logic             none_found;

  modport source (output valid, output center_x, output center_y, output hit_count,
                  output none_found, input ready);
  modport sink (input valid, input center_x, input center_y, input hit_count,
                input none_found, output ready);
endinterface

// ===== rtl/core/bcc_div.sv =====
// Radix-2 restoring divider producing one quotient bit per cycle.
module bcc_div
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  low;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // The quotient is known to fit in QUO_W bits, so the upper dividend bits
  // start out as the partial remainder and only QUO_W steps are needed.
  assign trial = {rem, low[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CNT_W'(dividend[SUM_W-1:QUO_W]);
      low <= dividend[QUO_W-1:0];
    end else if (busy) begin
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      low <= {low[QUO_W-2:0], fits};
    end
  end

  assign quotient = low;

endmodule

// ===== rtl/core/bcc_datapath.sv =====
// Datapath: configuration, position counters, moment sums, dividers and result register.
module bcc_datapath
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic [PIX_W-1:0]  pixel,
  input  bcc_cmd_t          cmd,
  output bcc_status_t       status,
  output logic [QUO_W-1:0]  center_x,
  output logic [QUO_W-1:0]  center_y,
  output logic [CNT_W-1:0]  hit_count,
  output logic              none_found
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [PIX_W-1:0] threshold;

  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic [CNT_W-1:0] pass_count;
  logic [SUM_W-1:0] column_sum;
  logic [SUM_W-1:0] row_sum;

  logic [CNT_W-1:0] pass_count_next;
  logic [SUM_W-1:0] column_sum_next;
  logic [SUM_W-1:0] row_sum_next;

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic             col_end;
  logic             row_end;
  logic             hit;

  logic [CNT_W-1:0] res_count;
  logic             res_none;
  logic [QUO_W-1:0] res_half_x;
  logic [QUO_W-1:0] res_half_y;
  logic [QUO_W-1:0] quo_x;
  logic [QUO_W-1:0] quo_y;
  logic             busy_x;
  logic             busy_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      threshold    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_THRESHOLD:    threshold    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign height_eff = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
  assign col_end    = ({1'b0, column} + DIM_W'(1)) >= width_eff;
  assign row_end    = ({1'b0, row} + DIM_W'(1)) >= height_eff;
  assign hit        = pixel > threshold;

  assign pass_count_next = pass_count + CNT_W'(hit);
  assign column_sum_next = hit ? column_sum + SUM_W'(column) : column_sum;
  assign row_sum_next    = hit ? row_sum + SUM_W'(row) : row_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      pass_count <= '0;
      column_sum <= '0;
      row_sum    <= '0;
    end else if (cmd.take) begin
      if (col_end) begin
        column <= '0;
        row    <= row_end ? '0 : row + POS_W'(1);
      end else begin
        column <= column + POS_W'(1);
      end
      if (col_end && row_end) begin
        pass_count <= '0;
        column_sum <= '0;
        row_sum    <= '0;
      end else begin
        pass_count <= pass_count_next;
        column_sum <= column_sum_next;
        row_sum    <= row_sum_next;
      end
    end
  end

  // Frame snapshot taken with the last pixel; it feeds the dividers.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_count  <= pass_count_next;
      res_none   <= pass_count_next == '0;
      res_half_x <= width_eff[DIM_W-1:1];
      res_half_y <= height_eff[DIM_W-1:1];
    end
  end

  bcc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (column_sum_next),
    .divisor  (res_count),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  bcc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (row_sum_next),
    .divisor  (res_count),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      center_x   <= res_none ? res_half_x : quo_x;
      center_y   <= res_none ? res_half_y : quo_y;
      hit_count  <= res_count;
      none_found <= res_none;
    end
  end

  assign status.frame_last = col_end && row_end;
  assign status.div_busy   = busy_x || busy_y;

endmodule

// ===== rtl/core/bcc_ctrl.sv =====
// Controller: pixel intake, division wait and result register handshake.
`include "binary_image_centroid_core_macros.svh"
module bcc_ctrl
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  bcc_status_t status,
  output bcc_cmd_t    cmd
);

  typedef enum logic {
    ST_RUN,
    ST_DIVIDE
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready      = state == ST_RUN;
  assign slot_free     = !out_valid || out_ready;
  assign cmd.take      = in_valid && in_ready;
  assign cmd.div_start = cmd.take && status.frame_last;
  assign cmd.load_out  = (state == ST_DIVIDE) && !status.div_busy && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (cmd.div_start) begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (cmd.load_out) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BCC_ASSERT_IMP(a_no_intake_while_dividing, clk, rst, status.div_busy, !in_ready)
  `BCC_ASSERT_IMP(a_load_needs_free_slot, clk, rst, cmd.load_out, !out_valid || out_ready)
  `BCC_ASSERT_NEXT(a_frame_end_starts_div, clk, rst, cmd.div_start, status.div_busy && !in_ready)

endmodule

// ===== rtl/core/binary_image_centroid_core.sv =====
// Top level of the binary image centroid core.
// The core takes 8-bit grayscale pixels in raster order at one pixel per clock and tracks
// the column and row itself from frame_width and frame_height (a value of 0 acts as 1 and
// values above 4096 saturate to 4096). A pixel counts when it is greater than threshold;
// each counted pixel adds one to a hit count and its column and row to two sums. With the
// last pixel of a frame the core snapshots the sums and runs two restoring dividers in
// parallel, one quotient bit per cycle, so the input is stalled after the last pixel while
// the dividers run their 12 divide steps and the result register is loaded. If the previous
// result has not been taken yet, the stall lasts until it is. The result register frees
// the pixel side as soon as it is loaded, so the next frame streams in while the result
// waits. An empty frame reports width/2 and height/2 with none_found set. Configuration
// registers (index 0 frame_width, 1 frame_height, 2 threshold) are written with cfg_we,
// cfg_index and cfg_data while the core is idle; index 3 is ignored.
module binary_image_centroid_core
  import bcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  bcc_pixel_if.sink          pixel_in,
  bcc_result_if.source       result_out
);

  // Command and status groups between the controller and the datapath.
  bcc_cmd_t    cmd;
  bcc_status_t status;

  // The controller owns the handshakes and decides when a pixel request is taken,
  // when division starts and when the result register is loaded.
  bcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the position counters, the moment sums,
  // the two dividers and the result payload register.
  bcc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel_in.pixel),
    .cmd        (cmd),
    .status     (status),
    .center_x   (result_out.center_x),
    .center_y   (result_out.center_y),
    .hit_count  (result_out.hit_count),
    .none_found (result_out.none_found)
  );

endmodule
